FILE: design/tgm_pkg.sv
// Shared types and constants of the tremolo gain modulator.
package tgm_pkg;

   localparam int GAIN_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_B_W    = 26;

   localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;
   localparam logic [15:0]       SINE_P   = 16'd14746;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [2:0]           wave_type;

   localparam csr_idx_type CSR_PHASE_STEP = 3'd0;
   localparam csr_idx_type CSR_WAVEFORM   = 3'd1;
   localparam csr_idx_type CSR_AMOUNT     = 3'd2;
   localparam csr_idx_type CSR_BIAS       = 3'd3;
   localparam csr_idx_type CSR_SATURATION = 3'd4;
   localparam csr_idx_type CSR_SAT_INV    = 3'd5;
   localparam csr_idx_type CSR_STEREO_OUT = 3'd6;

   localparam wave_type WAVE_SINE      = 3'd0;
   localparam wave_type WAVE_SQUARE    = 3'd1;
   localparam wave_type WAVE_TRIANGLE  = 3'd2;
   localparam wave_type WAVE_RAMP_UP   = 3'd3;
   localparam wave_type WAVE_RAMP_DOWN = 3'd4;

   localparam logic [30:0]        RST_PHASE_STEP = 31'd701800;
   localparam wave_type           RST_WAVEFORM   = WAVE_SINE;
   localparam logic [15:0]        RST_AMOUNT     = 16'd1270;
   localparam logic signed [15:0] RST_BIAS       = 16'sd0;
   localparam logic [16:0]        RST_SATURATION = 17'd49152;
   localparam logic [24:0]        RST_SAT_INV    = 25'd87381;
   localparam logic               RST_STEREO_OUT = 1'b1;

endpackage

FILE: design/tgm_if.sv
// Request, response and register write channel interfaces of the tremolo gain modulator.
interface tgm_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_left;
   logic signed [SAMPLE_BITS-1:0] in_right;
   modport source(output valid, output in_left, output in_right, input ready);
   modport sink(input valid, input in_left, input in_right, output ready);
endinterface

interface tgm_rsp_if #(parameter int SAMPLE_BITS = 24) ();
   import tgm_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   logic [GAIN_W-1:0]             gain_now;
   modport source(output valid, output out_left, output out_right, output gain_now,
                  input ready);
   modport sink(input valid, input out_left, input out_right, input gain_now,
                output ready);
endinterface

interface tgm_csr_if ();
   import tgm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/tremolo_gain_modulator.sv
// Tremolo gain modulator top level: LFO, gain shaping and sample scaling on one multiplier.
// Each request carries one stereo sample pair and yields one response with the scaled
// samples (the right one zero when stereo output is off) and the applied gain. A small
// sequencer runs every product through one shared registered multiplier; the sine
// waveform adds states SIN_A, SIN_B and SIN_C, enabled gain saturation adds SAT_U, SAT_V
// and SAT_G, and the block returns to idle before the next request is taken. The
// response sits in an output register, so the next request is taken while one still waits.
// Register writes are taken at any time and are meant to be issued while the block is idle.
module tremolo_gain_modulator #(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 24
) (
   input logic        clock,
   input logic        reset,
   tgm_req_if.sink    req_ch,
   tgm_rsp_if.source  rsp_ch,
   tgm_csr_if.sink    csr_ch
);
   import tgm_pkg::*;

   localparam int A_W = (SAMPLE_BITS > 19) ? SAMPLE_BITS : 19;
   localparam int B_W = MUL_B_W;
   localparam int P_W = A_W + B_W;

   localparam logic signed [P_W-1:0] ONE_Q16_P   = P_W'(65536);
   localparam logic signed [P_W-1:0] HALF_Q16_P  = P_W'(32768);
   localparam logic signed [P_W-1:0] ROUND_Q12_P = P_W'(2048);
   localparam logic signed [P_W-1:0] GAIN_MAX_P  = {{(P_W-GAIN_W){1'b0}}, GAIN_MAX};
   localparam logic signed [P_W-1:0] SMP_MAX_P   = P_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
   localparam logic signed [P_W-1:0] SMP_MIN_P   = -SMP_MAX_P - P_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SIN_A, ST_SIN_B, ST_SIN_C, ST_LFO, ST_GAIN,
      ST_SAT_U, ST_SAT_V, ST_SAT_G, ST_LEFT, ST_RIGHT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [30:0]        phase_step_ff, phase_step_in;
   wave_type           waveform_ff, waveform_in;
   logic [15:0]        amount_ff, amount_in;
   logic signed [15:0] bias_ff, bias_in;
   logic [16:0]        saturation_ff, saturation_in;
   logic [24:0]        sat_inv_ff, sat_inv_in;
   logic               stereo_ff, stereo_in;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] x_left_ff, x_left_in;
   logic signed [SAMPLE_BITS-1:0] x_right_ff, x_right_in;
   logic [15:0]                   p_ff, p_in;
   logic [16:0]                   y_ff, y_in;
   logic [GAIN_W-1:0]             gain_ff, gain_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_left_in;
   logic signed [SAMPLE_BITS-1:0] out_right_ff, out_right_in;
   logic [GAIN_W-1:0]             gain_now_ff, gain_now_in;

   logic signed [A_W-1:0] mul_a;
   logic signed [B_W-1:0] mul_b;
   logic signed [P_W-1:0] prod_ff;

   logic                  req_take;
   logic signed [16:0]    p_ext;
   logic signed [16:0]    m_abs;
   logic signed [P_W-1:0] sin_y_full;
   logic signed [P_W-1:0] sin_d_full;
   logic signed [P_W-1:0] sin_v_full;
   logic signed [19:0]    sin_val;
   logic signed [19:0]    tri_a;
   logic signed [19:0]    tri_aa;
   logic signed [19:0]    tri_b;
   logic signed [19:0]    tri_bb;
   logic signed [19:0]    ramp;
   logic signed [19:0]    lfo;
   logic signed [19:0]    lfo_sum;
   logic signed [P_W-1:0] g_full;
   logic [GAIN_W-1:0]     g_clamped;
   logic signed [P_W-1:0] sat_t;
   logic [16:0]           sat_u;
   logic [16:0]           sat_v;
   logic signed [P_W-1:0] sat_g_full;
   logic [GAIN_W-1:0]     sat_g_clamped;
   logic signed [P_W-1:0] smp_full;
   logic signed [SAMPLE_BITS-1:0] smp_sat;

   tgm_mul #(.A_W(A_W), .B_W(B_W)) u_tgm_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign req_take         = req_ch.valid && (state_ff == ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_left  = out_left_ff;
   assign rsp_ch.out_right = out_right_ff;
   assign rsp_ch.gain_now  = gain_now_ff;

   always_comb begin
      p_ext      = {p_ff[15], p_ff};
      m_abs      = p_ff[15] ? -p_ext : p_ext;
      sin_y_full = (P_W'(m_abs) <<< 3) - (prod_ff >>> 12);
      sin_d_full = P_W'($signed({1'b0, y_ff})) - (prod_ff >>> 16);
      sin_v_full = P_W'($signed({1'b0, y_ff})) - ((prod_ff + HALF_Q16_P) >>> 16);
      sin_val    = p_ff[15] ? -sin_v_full[19:0] : sin_v_full[19:0];

      tri_a  = 20'($signed(p_ff)) + 20'sd16384;
      tri_aa = tri_a[19] ? -tri_a : tri_a;
      tri_b  = 20'sd32768 - tri_aa;
      tri_bb = tri_b[19] ? -tri_b : tri_b;
      ramp   = 20'($signed({p_ff, 1'b0}));

      case (waveform_ff)
         WAVE_SINE:      lfo = sin_val;
         WAVE_SQUARE:    lfo = p_ff[15] ? -20'sd65536 : 20'sd65536;
         WAVE_TRIANGLE:  lfo = 20'sd65536 - (tri_bb <<< 2);
         WAVE_RAMP_UP:   lfo = ramp;
         WAVE_RAMP_DOWN: lfo = -ramp;
         default:        lfo = 20'sd0;
      endcase
      lfo_sum = lfo + 20'($signed({bias_ff, 1'b0}));

      g_full = ONE_Q16_P + ((prod_ff + ROUND_Q12_P) >>> 12);
      if (g_full < P_W'(0)) begin
         g_clamped = '0;
      end else if (g_full > GAIN_MAX_P) begin
         g_clamped = GAIN_MAX;
      end else begin
         g_clamped = g_full[GAIN_W-1:0];
      end

      sat_t = prod_ff >>> 17;
      if (sat_t > ONE_Q16_P) begin
         sat_u = '0;
      end else begin
         sat_u = 17'(ONE_Q16_P - sat_t);
      end
      sat_v = 17'(ONE_Q16_P - (prod_ff >>> 16));

      sat_g_full = (prod_ff + HALF_Q16_P) >>> 16;
      if (sat_g_full > GAIN_MAX_P) begin
         sat_g_clamped = GAIN_MAX;
      end else begin
         sat_g_clamped = sat_g_full[GAIN_W-1:0];
      end

      smp_full = (prod_ff + HALF_Q16_P) >>> 16;
      if (smp_full > SMP_MAX_P) begin
         smp_sat = SMP_MAX_P[SAMPLE_BITS-1:0];
      end else if (smp_full < SMP_MIN_P) begin
         smp_sat = SMP_MIN_P[SAMPLE_BITS-1:0];
      end else begin
         smp_sat = smp_full[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      phase_step_in = phase_step_ff;
      waveform_in   = waveform_ff;
      amount_in     = amount_ff;
      bias_in       = bias_ff;
      saturation_in = saturation_ff;
      sat_inv_in    = sat_inv_ff;
      stereo_in     = stereo_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PHASE_STEP: phase_step_in = csr_ch.data[30:0];
            CSR_WAVEFORM:   waveform_in   = csr_ch.data[2:0];
            CSR_AMOUNT:     amount_in     = csr_ch.data[15:0];
            CSR_BIAS:       bias_in       = $signed(csr_ch.data[15:0]);
            CSR_SATURATION: saturation_in = csr_ch.data[16:0];
            CSR_SAT_INV:    sat_inv_in    = csr_ch.data[24:0];
            CSR_STEREO_OUT: stereo_in     = csr_ch.data[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      x_left_in    = x_left_ff;
      x_right_in   = x_right_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      gain_in      = gain_ff;
      left_in      = left_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      gain_now_in  = gain_now_ff;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_left_in  = req_ch.in_left;
               x_right_in = req_ch.in_right;
               p_in       = phase_ff[PHASE_BITS-1 -: 16];
               phase_in   = phase_ff + PHASE_BITS'(phase_step_ff[30 -: PHASE_BITS-1]);
               state_in   = (waveform_ff == WAVE_SINE) ? ST_SIN_A : ST_LFO;
            end
         end
         ST_SIN_A: begin
            mul_a    = A_W'(m_abs);
            mul_b    = B_W'(m_abs);
            state_in = ST_SIN_B;
         end
         ST_SIN_B: begin
            y_in     = sin_y_full[16:0];
            mul_a    = A_W'($signed({1'b0, sin_y_full[16:0]}));
            mul_b    = B_W'($signed({1'b0, sin_y_full[16:0]}));
            state_in = ST_SIN_C;
         end
         ST_SIN_C: begin
            mul_a    = A_W'($signed({1'b0, sin_d_full[16:0]}));
            mul_b    = B_W'($signed({1'b0, SINE_P}));
            state_in = ST_LFO;
         end
         ST_LFO: begin
            mul_a    = A_W'(lfo_sum);
            mul_b    = B_W'($signed({1'b0, amount_ff}));
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = g_clamped;
            mul_a    = A_W'($signed({1'b0, saturation_ff}));
            mul_b    = B_W'($signed({1'b0, g_clamped}));
            state_in = (saturation_ff == '0) ? ST_LEFT : ST_SAT_U;
         end
         ST_SAT_U: begin
            mul_a    = A_W'($signed({1'b0, sat_u}));
            mul_b    = B_W'($signed({1'b0, sat_u}));
            state_in = ST_SAT_V;
         end
         ST_SAT_V: begin
            mul_a    = A_W'($signed({1'b0, sat_v}));
            mul_b    = B_W'($signed({1'b0, sat_inv_ff}));
            state_in = ST_SAT_G;
         end
         ST_SAT_G: begin
            gain_in  = sat_g_clamped;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            mul_a    = A_W'(x_left_ff);
            mul_b    = B_W'($signed({1'b0, gain_ff}));
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            left_in  = smp_sat;
            mul_a    = A_W'(x_right_ff);
            mul_b    = B_W'($signed({1'b0, gain_ff}));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            mul_a = A_W'(x_right_ff);
            mul_b = B_W'($signed({1'b0, gain_ff}));
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_left_in  = left_ff;
               out_right_in = stereo_ff ? smp_sat : '0;
               gain_now_in  = gain_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         phase_step_ff <= RST_PHASE_STEP;
         waveform_ff   <= RST_WAVEFORM;
         amount_ff     <= RST_AMOUNT;
         bias_ff       <= RST_BIAS;
         saturation_ff <= RST_SATURATION;
         sat_inv_ff    <= RST_SAT_INV;
         stereo_ff     <= RST_STEREO_OUT;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_step_ff <= phase_step_in;
         waveform_ff   <= waveform_in;
         amount_ff     <= amount_in;
         bias_ff       <= bias_in;
         saturation_ff <= saturation_in;
         sat_inv_ff    <= sat_inv_in;
         stereo_ff     <= stereo_in;
      end
      x_left_ff    <= x_left_in;
      x_right_ff   <= x_right_in;
      p_ff         <= p_in;
      y_ff         <= y_in;
      gain_ff      <= gain_in;
      left_ff      <= left_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      gain_now_ff  <= gain_now_in;
   end

endmodule

FILE: design/tgm_mul.sv
// Shared signed multiplier with a registered product.
module tgm_mul #(
   parameter int A_W = 24,
   parameter int B_W = 26
) (
   input  logic                        clock,
   input  logic signed [A_W-1:0]       mul_a,
   input  logic signed [B_W-1:0]       mul_b,
   output logic signed [A_W+B_W-1:0]   prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: design/tgm_checker.sv
// Port-level checks of the tremolo gain modulator and their binding to the top level.
module tgm_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] out_left,
   input logic [SAMPLE_BITS-1:0] out_right,
   input logic [23:0]            gain_now
);

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a previous request was still in work");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !$rose(rsp_valid))
      else $error("response appeared too soon after a request");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(out_left) && $stable(out_right) && $stable(gain_now))
      else $error("stalled response changed");

endmodule

bind tremolo_gain_modulator tgm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tgm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_left  (rsp_ch.out_left),
   .out_right (rsp_ch.out_right),
   .gain_now  (rsp_ch.gain_now)
);

FILE: tb/tb.sv
// Self-checking testbench of the tremolo gain modulator with its own gain and LFO predictor.
module tb;
   import tgm_pkg::*;

   localparam int          SAMPLE_W     = 24;
   localparam longint      SAMPLE_MAX   = 8388607;
   localparam longint      SAMPLE_MIN   = -8388608;
   localparam longint      GAIN_CEIL    = longint'(GAIN_MAX);
   localparam longint      SINE_K       = longint'(SINE_P);
   localparam csr_idx_type CSR_SPARE    = 3'd7;
   localparam int          IDLE_CYCLES  = 12;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RAND_PHASES  = 10;
   localparam int          PHASE_PAIRS  = 125;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } sample_pair_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [GAIN_W-1:0]          gain;
   } scaled_pair_type;

   logic clock;
   logic reset = 1'b1;

   tgm_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   tgm_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_bus ();
   tgm_csr_if                           csr_bus ();

   tremolo_gain_modulator #(
      .PHASE_BITS (32),
      .SAMPLE_BITS(SAMPLE_W)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   // Register copies and LFO phase of the predictor.
   logic [30:0]        step_q32     = RST_PHASE_STEP;
   wave_type           waveform_sel = RST_WAVEFORM;
   logic [15:0]        amount_q12   = RST_AMOUNT;
   logic signed [15:0] bias_q15     = RST_BIAS;
   logic [16:0]        sat_q16      = RST_SATURATION;
   logic [24:0]        sat_inv_q16  = RST_SAT_INV;
   logic               stereo_on    = RST_STEREO_OUT;
   logic [31:0]        lfo_phase    = '0;

   sample_pair_type pending_pairs[$];
   scaled_pair_type expected_outputs[$];

   logic        steady_flow = 1'b0;
   logic        hold_kick   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned req_wait    = 0;
   int unsigned rsp_wait    = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned sent_count  = 0;
   int unsigned checked_count = 0;
   int unsigned setting_count = 0;
   int unsigned clip_count  = 0;
   int unsigned bypass_count = 0;
   int unsigned mono_count  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint lfo_level(longint pos);
      longint mag, y, d, a, b;
      case (waveform_sel)
         WAVE_SINE: begin
            mag = (pos < 0) ? -pos : pos;
            y = 8 * mag - ((mag * mag) >>> 12);
            d = y - ((y * y) >>> 16);
            y = y - ((d * SINE_K + 32768) >>> 16);
            return (pos < 0) ? -y : y;
         end
         WAVE_SQUARE: return (pos >= 0) ? 65536 : -65536;
         WAVE_TRIANGLE: begin
            a = pos + 16384;
            a = (a < 0) ? -a : a;
            b = 32768 - a;
            b = (b < 0) ? -b : b;
            return 65536 - 4 * b;
         end
         WAVE_RAMP_UP: return 2 * pos;
         WAVE_RAMP_DOWN: return -2 * pos;
         default: return 0;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] clip_sample(longint x, longint g);
      longint y;
      y = (x * g + 32768) >>> 16;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
         clip_count++;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
         clip_count++;
      end
      return y[SAMPLE_W-1:0];
   endfunction

   function automatic scaled_pair_type scale_pair(logic signed [SAMPLE_W-1:0] left_smp,
                                                  logic signed [SAMPLE_W-1:0] right_smp);
      longint pos, lfo, amt, raw, sat, t, u, v, applied;
      scaled_pair_type res;
      pos = $signed(lfo_phase[31:16]);
      lfo = lfo_level(pos);
      amt = amount_q12;
      raw = 65536 + ((amt * (lfo + 2 * longint'(bias_q15)) + 2048) >>> 12);
      if (raw < 0) raw = 0;
      if (raw > GAIN_CEIL) raw = GAIN_CEIL;
      sat = sat_q16;
      if (sat == 0) begin
         applied = raw;
         bypass_count++;
      end else begin
         t = (sat * raw) >>> 17;
         if (t > 65536) t = 65536;
         u = 65536 - t;
         v = 65536 - ((u * u) >>> 16);
         applied = (v * longint'(sat_inv_q16) + 32768) >>> 16;
         if (applied > GAIN_CEIL) applied = GAIN_CEIL;
      end
      res.left = clip_sample(left_smp, applied);
      if (stereo_on) begin
         res.right = clip_sample(right_smp, applied);
      end else begin
         res.right = '0;
         mono_count++;
      end
      res.gain = applied[GAIN_W-1:0];
      lfo_phase = lfo_phase + {1'b0, step_q32};
      return res;
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 511) - 256);
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_PHASE_STEP: step_q32     = value[30:0];
         CSR_WAVEFORM:   waveform_sel = value[2:0];
         CSR_AMOUNT:     amount_q12   = value[15:0];
         CSR_BIAS:       bias_q15     = value[15:0];
         CSR_SATURATION: sat_q16      = value[16:0];
         CSR_SAT_INV:    sat_inv_q16  = value[24:0];
         CSR_STEREO_OUT: stereo_on    = value[0];
         default: ;
      endcase
   endtask

   task automatic queue_pairs(int unsigned n);
      repeat (n) pending_pairs.push_back('{left: draw_sample(), right: draw_sample()});
      sent_count += n;
      setting_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_bus.valid || expected_outputs.size() != 0);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      logic            in_flight;
      sample_pair_type next_pair;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_wait <= 0;
      end else begin
         in_flight = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_outputs.push_back(scale_pair(req_bus.in_left, req_bus.in_right));
            in_flight = 1'b0;
         end
         if (!in_flight) begin
            if (req_wait != 0) begin
               req_wait <= req_wait - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               next_pair = pending_pairs.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.in_left  <= next_pair.left;
               req_bus.in_right <= next_pair.right;
               req_wait <= steady_flow ? 0 : $urandom_range(0, 6);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      int unsigned     stall_next;
      scaled_pair_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         stall_next = (rsp_wait != 0) ? rsp_wait - 1 : 0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            stall_next = steady_flow ? 0 : $urandom_range(0, 6);
            if (expected_outputs.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Response without a request: left %0d right %0d gain %0d",
                           rsp_bus.out_left, rsp_bus.out_right, rsp_bus.gain_now);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_bus.out_left !== want.left || rsp_bus.out_right !== want.right ||
                   rsp_bus.gain_now !== want.gain) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("Response %0d: expected left %0d right %0d gain %0d, got %0d %0d %0d",
                              checked_count, want.left, want.right, want.gain,
                              rsp_bus.out_left, rsp_bus.out_right, rsp_bus.gain_now);
               end
            end
            checked_count++;
         end
         rsp_wait <= stall_next;
         rsp_bus.ready <= (stall_next == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] reg_value;
      longint                recip;
      req_bus.valid    = 1'b0;
      req_bus.in_left  = '0;
      req_bus.in_right = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings with full-scale and tiny samples.
      pending_pairs.push_back('{left: 24'h7FFFFF, right: 24'h800000});
      pending_pairs.push_back('{left: 24'h800000, right: 24'h7FFFFF});
      pending_pairs.push_back('{left: 24'h000000, right: 24'h000000});
      pending_pairs.push_back('{left: 24'hFFFFFF, right: 24'h000001});
      sent_count += 4;
      setting_count++;
      wait_idle();

      // Every waveform code, the undefined ones included.
      write_reg(CSR_PHASE_STEP, 32'h1C00_0000);
      for (int w = 0; w < 8; w++) begin
         write_reg(CSR_WAVEFORM, 32'(w));
         queue_pairs(2);
         wait_idle();
      end

      // Strong negative bias drives the raw gain to zero.
      write_reg(CSR_WAVEFORM, 32'(WAVE_RAMP_DOWN));
      write_reg(CSR_AMOUNT, 32'd40960);
      write_reg(CSR_BIAS, 32'h0000_8000);
      write_reg(CSR_SATURATION, 32'd0);
      queue_pairs(2);
      wait_idle();

      // Out-of-range amount and reciprocal overflow the gain; mono output; spare index.
      write_reg(CSR_AMOUNT, 32'h0000_FFFF);
      write_reg(CSR_BIAS, 32'h0000_7FFF);
      write_reg(CSR_SATURATION, 32'd65536);
      write_reg(CSR_SAT_INV, 32'h01FF_FFFF);
      write_reg(CSR_STEREO_OUT, 32'd0);
      write_reg(CSR_SPARE, $urandom());
      pending_pairs.push_back('{left: 24'h7FFFFF, right: 24'h7FFFFF});
      pending_pairs.push_back('{left: 24'h800000, right: 24'h800000});
      sent_count += 2;
      setting_count++;
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         steady_flow = (ph % 4 == 1);
         case ($urandom_range(0, 3))
            0: reg_value = 32'd0;
            1: reg_value = 32'hFFFF_FFFF;
            2: reg_value = $urandom_range(0, 4000000);
            default: reg_value = $urandom();
         endcase
         write_reg(CSR_PHASE_STEP, reg_value);
         reg_value = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 4);
         write_reg(CSR_WAVEFORM, reg_value);
         case ($urandom_range(0, 4))
            0: reg_value = 32'd0;
            1: reg_value = 32'd40960;
            2: reg_value = $urandom();
            default: reg_value = $urandom_range(0, 40960);
         endcase
         write_reg(CSR_AMOUNT, reg_value);
         case ($urandom_range(0, 4))
            0: reg_value = 32'h0000_7FFF;
            1: reg_value = 32'hFFFF_8000;
            2: reg_value = 32'd0;
            default: reg_value = $urandom();
         endcase
         write_reg(CSR_BIAS, reg_value);
         case ($urandom_range(0, 4))
            0: reg_value = 32'd0;
            1: reg_value = 32'd65536;
            2: reg_value = $urandom();
            default: reg_value = $urandom_range(1, 65536);
         endcase
         write_reg(CSR_SATURATION, reg_value);
         if (sat_q16 != 0 && $urandom_range(0, 3) != 0) begin
            recip = 64'sd4294967296 / longint'(sat_q16);
            if (recip > 16777216) recip = 16777216;
            reg_value = recip[31:0];
         end else begin
            reg_value = $urandom();
         end
         write_reg(CSR_SAT_INV, reg_value);
         reg_value = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1);
         write_reg(CSR_STEREO_OUT, reg_value);
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_SPARE, $urandom());
         queue_pairs(PHASE_PAIRS);
         if (ph % 3 == 0) begin
            @(negedge clock) hold_kick = 1'b1;
            @(negedge clock) hold_kick = 1'b0;
         end
         wait_idle();
      end

      error_count += expected_outputs.size();
      $display("Covered %0d sample pairs over %0d register settings, %0d responses compared.",
               sent_count, setting_count, checked_count);
      $display("Clipped samples: %0d, saturation bypassed: %0d, mono requests: %0d.",
               clip_count, bypass_count, mono_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
